FILE: src/ipg_pkg.sv
// shared constants for the integer partition generator
// no dependencies; imported by the core and its port checker
package ipg_pkg;

    localparam int MAX_TOTAL = 64;

    localparam int VAL_W  = 7;                    // part values and totals
    localparam int POS_W  = 6;                    // part position
    localparam int CNT_W  = 7;                    // part count, pivot, counters
    localparam int ADDR_W = $clog2(MAX_TOTAL);    // parts memory address

    localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_TOTAL);
    localparam logic [VAL_W-1:0] TOTAL_RESET = VAL_W'(4);
    localparam logic [VAL_W-1:0] ONE_VAL     = VAL_W'(1);
    localparam logic [VAL_W-1:0] TWO_VAL     = VAL_W'(2);

endpackage

FILE: src/integer_partition_generator.sv
// integer partition generator top level: ZS1 sequencer around one parts memory
// depends on ipg_pkg
//
// Every accepted request returns one partition of total, one part per output
// transfer, largest part first, in descending lexicographic (ZS1) order. A request
// with start_req high, or any request before the first start, restarts at [total];
// the total held from the last cfg_valid is used, clamped to 1..64. Once the all-ones
// partition has gone out, each further next request returns a single exhausted transfer.
// The parts live in a 64 x 7 synchronous memory with one port of each kind, so
// everything is paced by it. After the accept, a start emits its single part; a
// next rewrites the pivot part read during the accept, then, unless the pivot part
// was a two, writes the refilled parts and closes the refill, then emits the parts
// in order; an exhausted request sends its one marker transfer. One request is
// worked at a time; the next one is taken while the last part still waits on
// out_stall.
module integer_partition_generator
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ipg_pkg::VAL_W-1:0]  total,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       start_req,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ipg_pkg::VAL_W-1:0]  part_value,
    output logic [ipg_pkg::POS_W-1:0]  part_position,
    output logic [ipg_pkg::CNT_W-1:0]  parts_in_partition,
    output logic                       last_part,
    output logic                       final_partition,
    output logic                       exhausted
);
    import ipg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PIVOT, S_FILL, S_EMIT, S_EXH} state_t;

    state_t                 state_reg;
    logic [VAL_W-1:0]       total_reg;
    logic                   started_reg;
    logic [CNT_W-1:0]       m_reg;
    logic [CNT_W-1:0]       h_reg;
    logic signed [7:0]      t_reg;
    logic [VAL_W-1:0]       r_reg;
    logic [VAL_W-1:0]       first_reg;
    logic [MAX_TOTAL-1:0]   vld_reg;
    logic [CNT_W-1:0]       rd_idx_reg;
    logic [CNT_W-1:0]       ld_idx_reg;
    logic                   pend_reg;

    logic                   out_valid_reg;
    logic [VAL_W-1:0]       value_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   last_reg;
    logic                   final_reg;
    logic                   exh_reg;

    // parts memory and its registered read
    logic [VAL_W-1:0]       mem [MAX_TOTAL];
    logic [VAL_W-1:0]       rdata_reg;
    logic                   rvld_reg;

    logic                   accept;
    logic                   do_start;
    logic                   do_exh;
    logic                   do_next;
    logic                   h_ok;
    logic [CNT_W-1:0]       hm1;
    logic [VAL_W-1:0]       x;
    logic [VAL_W-1:0]       n_start;
    logic signed [7:0]      t_init;
    logic                   fill_go;
    logic                   out_free;
    logic                   load;
    logic                   out_set;
    logic                   issue;
    logic                   rd_en;
    logic [ADDR_W-1:0]      raddr;
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [VAL_W-1:0]       wdata;
    logic [VAL_W-1:0]       cur_part;
    logic [CNT_W-1:0]       m_last;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        accept   = in_valid && !in_stall;
        do_start = accept && (start_req || !started_reg);
        do_exh   = accept && !do_start && (first_reg == ONE_VAL);
        do_next  = accept && !do_start && !do_exh;

        h_ok     = (h_reg != '0) && (h_reg <= MAX_CNT);
        hm1      = h_reg - CNT_W'(1);
        // parts outside the store, or never written since start, read as one
        x        = (h_ok && rvld_reg) ? rdata_reg : ONE_VAL;
        n_start  = (total_reg == '0) ? ONE_VAL :
                   (total_reg > VAL_W'(MAX_CNT)) ? VAL_W'(MAX_CNT) : total_reg;
        t_init   = $signed({1'b0, m_reg}) - $signed({1'b0, h_reg}) + 8'sd1;
        fill_go  = ($signed({t_reg[7], t_reg}) >= $signed({2'b00, r_reg}))
                   && (h_reg < MAX_CNT);

        out_free = !out_valid_reg || !out_stall;
        load     = (state_reg == S_EMIT) && pend_reg && out_free;
        out_set  = load || ((state_reg == S_EXH) && out_free);
        // rdata holds until the next read, so a read may be issued as it is consumed
        issue    = (state_reg == S_EMIT) && (rd_idx_reg < m_reg) && (!pend_reg || load);
        rd_en    = do_next || issue;
        raddr    = do_next ? hm1[ADDR_W-1:0] : rd_idx_reg[ADDR_W-1:0];

        cur_part = rvld_reg ? rdata_reg : ONE_VAL;
        m_last   = m_reg - CNT_W'(1);

        // one write a cycle; writes finish before emission reads start
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (do_start)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = n_start;
        end
        else if (state_reg == S_PIVOT)
        begin
            we    = h_ok;
            waddr = hm1[ADDR_W-1:0];
            wdata = (x == TWO_VAL) ? ONE_VAL : (x - ONE_VAL);
        end
        else if (state_reg == S_FILL)
        begin
            if (fill_go)
            begin
                we    = 1'b1;
                waddr = h_reg[ADDR_W-1:0];
                wdata = r_reg;
            end
            else if ((t_reg > 8'sd1) && (h_reg < MAX_CNT))
            begin
                we    = 1'b1;
                waddr = h_reg[ADDR_W-1:0];
                wdata = t_reg[VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
            rvld_reg  <= vld_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= TOTAL_RESET;
            started_reg   <= 1'b0;
            m_reg         <= CNT_W'(1);
            h_reg         <= CNT_W'(1);
            t_reg         <= '0;
            r_reg         <= '0;
            first_reg     <= ONE_VAL;
            vld_reg       <= '0;
            rd_idx_reg    <= '0;
            ld_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            final_reg     <= 1'b0;
            exh_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                total_reg <= total;
            end

            if (do_start)
            begin
                // a start writes only the first part
                vld_reg     <= MAX_TOTAL'(1);
                started_reg <= 1'b1;
            end
            if (we)
            begin
                if (!do_start)
                begin
                    vld_reg[waddr] <= 1'b1;
                end
                if (waddr == '0)
                begin
                    first_reg <= wdata;
                end
            end

            if (out_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (do_start)
                    begin
                        m_reg      <= CNT_W'(1);
                        h_reg      <= CNT_W'(1);
                        rd_idx_reg <= '0;
                        ld_idx_reg <= '0;
                        state_reg  <= S_EMIT;
                    end
                    else if (do_exh)
                    begin
                        state_reg <= S_EXH;
                    end
                    else if (do_next)
                    begin
                        state_reg <= S_PIVOT;
                    end
                end
                S_PIVOT:
                begin
                    if (x == TWO_VAL)
                    begin
                        m_reg      <= (m_reg >= MAX_CNT) ? MAX_CNT : (m_reg + CNT_W'(1));
                        h_reg      <= (h_reg == '0) ? '0 : hm1;
                        rd_idx_reg <= '0;
                        ld_idx_reg <= '0;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        r_reg     <= x - ONE_VAL;
                        t_reg     <= t_init;
                        state_reg <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    if (fill_go)
                    begin
                        h_reg <= h_reg + CNT_W'(1);
                        t_reg <= t_reg - $signed({1'b0, r_reg});
                    end
                    else
                    begin
                        if (t_reg == 8'sd0)
                        begin
                            m_reg <= (h_reg == '0) ? CNT_W'(1) : h_reg;
                        end
                        else
                        begin
                            m_reg <= (h_reg >= MAX_CNT) ? MAX_CNT : (h_reg + CNT_W'(1));
                            if (t_reg > 8'sd1)
                            begin
                                h_reg <= (h_reg >= MAX_CNT) ? MAX_CNT : (h_reg + CNT_W'(1));
                            end
                        end
                        rd_idx_reg <= '0;
                        ld_idx_reg <= '0;
                        state_reg  <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                        pend_reg   <= 1'b1;
                    end
                    else if (load)
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (load)
                    begin
                        value_reg     <= cur_part;
                        pos_reg       <= ld_idx_reg[POS_W-1:0];
                        count_reg     <= m_reg;
                        last_reg      <= (ld_idx_reg == m_last);
                        final_reg     <= (first_reg == ONE_VAL);
                        exh_reg       <= 1'b0;
                        ld_idx_reg    <= ld_idx_reg + CNT_W'(1);
                        if (ld_idx_reg == m_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EXH:
                begin
                    if (out_free)
                    begin
                        value_reg     <= '0;
                        pos_reg       <= '0;
                        count_reg     <= '0;
                        last_reg      <= 1'b1;
                        final_reg     <= 1'b0;
                        exh_reg       <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign part_value         = value_reg;
    assign part_position      = pos_reg;
    assign parts_in_partition = count_reg;
    assign last_part          = last_reg;
    assign final_partition    = final_reg;
    assign exhausted          = exh_reg;

endmodule

FILE: src/ipg_checker.sv
// port-level checker for the integer partition generator, with its bind
// depends on ipg_pkg; attached to integer_partition_generator
module ipg_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [ipg_pkg::VAL_W-1:0]  part_value,
    input logic [ipg_pkg::POS_W-1:0]  part_position,
    input logic [ipg_pkg::CNT_W-1:0]  parts_in_partition,
    input logic                       last_part,
    input logic                       final_partition,
    input logic                       exhausted
);
    import ipg_pkg::*;

    // exhausted transfer is a lone marker with empty payload
    a_exh_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && exhausted) |->
            (part_value == '0) && (parts_in_partition == '0) && last_part
            && !final_partition && (part_position == '0))
        else $error("malformed exhausted transfer");

    // a real part is nonzero and its position agrees with the count and last flag
    a_part_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !exhausted) |->
            (part_value != '0)
            && (CNT_W'(part_position) < parts_in_partition)
            && (last_part == ((CNT_W'(part_position) + CNT_W'(1)) == parts_in_partition)))
        else $error("part position, count and last flag disagree");

    // no new request is taken while a partition is only partly delivered
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_part) |-> in_stall)
        else $error("request taken in the middle of a partition");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(part_value)
            && $stable(part_position) && $stable(last_part))
        else $error("stalled output changed");

endmodule

bind integer_partition_generator ipg_checker u_ipg_checker (.*);
